### rtl/p256dc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// P-256 point decompression package
// Shared types, curve constants and controller/datapath command types.
// ----------------------------------------------------------------------------
package p256dc_pkg;

    localparam logic [255:0] MOD_P =
        256'hFFFFFFFF00000001000000000000000000000000FFFFFFFFFFFFFFFFFFFFFFFF;
    localparam logic [255:0] CURVE_A =
        256'hFFFFFFFF00000001000000000000000000000000FFFFFFFFFFFFFFFFFFFFFFFC;
    localparam logic [255:0] CURVE_B =
        256'h5AC635D8AA3A93E7B3EBBD55769886BC651D06B0CC53B0F63BCE3C3E27D2604B;
    localparam logic [255:0] ROOT_EXP =
        256'h3FFFFFFFC0000000400000000000000000000000400000000000000000000000;

    localparam logic [7:0] PREFIX_EVEN = 8'h02;
    localparam logic [7:0] PREFIX_ODD  = 8'h03;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_PFX = 2'd1;
    localparam logic [1:0] ST_NO_ROOT = 2'd2;

    typedef struct packed {
        logic [7:0]  prefix;
        logic [63:0] x_w0;
        logic [63:0] x_w1;
        logic [63:0] x_w2;
        logic [63:0] x_w3;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] y_w0;
        logic [63:0] y_w1;
        logic [63:0] y_w2;
        logic [63:0] y_w3;
    } t_rsp;

    // multiplier operand selects
    typedef enum logic [2:0] {
        OP_X     = 3'd0,
        OP_ALPHA = 3'd1,
        OP_ACC   = 3'd2,
        OP_A     = 3'd3,
        OP_R     = 3'd4
    } t_opsel;

    // destination of a finished product
    typedef enum logic [2:0] {
        DST_ACC   = 3'd0,
        DST_T     = 3'd1,
        DST_R     = 3'd2,
        DST_CHK   = 3'd3,
        DST_ALPHA = 3'd4
    } t_dst;

    typedef struct packed {
        logic   load;      // capture request and reduce x
        logic   mul_start;
        t_opsel op_a;
        t_opsel op_b;
        t_dst   dst;
        logic   alpha_fin; // alpha = acc + t + b
        logic   r_init;    // r = 1
        logic   neg_en;    // register p - r
        logic   rsp_load;  // build response
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic exp_bit;
    } t_sts;

endpackage

### rtl/p256dc_mulmod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// P-256 modular multiplier
// Bit-serial double-and-add, one bit of b per cycle.
// ----------------------------------------------------------------------------
module p256dc_mulmod (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [255:0] i_a,
    input  logic [255:0] i_b,
    output logic         o_done,
    output logic [255:0] o_prod
);

    logic [255:0] r_acc, n_acc;
    logic [255:0] r_a;
    logic [255:0] r_b;
    logic [7:0]   r_cnt;
    logic         r_busy;
    logic         r_done;

    logic [256:0] dbl, add;
    logic [255:0] dbl_red;

    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, p256dc_pkg::MOD_P}) ?
                  dbl[255:0] - p256dc_pkg::MOD_P : dbl[255:0];
        add     = {1'b0, dbl_red} + {1'b0, r_a};
        n_acc   = dbl_red;
        if (r_b[255]) begin
            n_acc = (add >= {1'b0, p256dc_pkg::MOD_P}) ?
                    add[255:0] - p256dc_pkg::MOD_P : add[255:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 8'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 8'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 8'd1;
                if (r_cnt == 8'd255) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[254:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### rtl/p256dc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// P-256 decompression datapath
// Operand registers, shared multiplier, curve-equation adds and result build.
// ----------------------------------------------------------------------------
module p256dc_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  p256dc_pkg::t_req     i_req,
    input  p256dc_pkg::t_cmd     i_cmd,
    input  logic [7:0]           i_bit_idx,
    output p256dc_pkg::t_sts     o_sts,
    output logic                 o_pfx_ok,
    output p256dc_pkg::t_rsp     o_rsp
);

    logic [255:0] r_x, r_alpha, r_acc, r_t, r_r, r_chk;
    logic         r_want;
    logic         r_pfx_ok;
    p256dc_pkg::t_rsp r_rsp;

    logic [255:0] xin, opa, opb, prod;
    logic         mdone;
    logic [256:0] s1, s2;
    logic [255:0] s1r, s2r;
    logic         pfx_ok;
    logic [255:0] neg;

    function automatic logic [255:0] sel(input p256dc_pkg::t_opsel s,
                                         input logic [255:0] x,
                                         input logic [255:0] al,
                                         input logic [255:0] ac,
                                         input logic [255:0] r);
        logic [255:0] v;
        unique case (s)
            p256dc_pkg::OP_X:     v = x;
            p256dc_pkg::OP_ALPHA: v = al;
            p256dc_pkg::OP_ACC:   v = ac;
            p256dc_pkg::OP_A:     v = p256dc_pkg::CURVE_A;
            p256dc_pkg::OP_R:     v = r;
            default:              v = r;
        endcase
        return v;
    endfunction

    assign opa = sel(i_cmd.op_a, r_x, r_alpha, r_acc, r_r);
    assign opb = sel(i_cmd.op_b, r_x, r_alpha, r_acc, r_r);

    p256dc_mulmod u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.mul_start),
        .i_a    (opa),
        .i_b    (opb),
        .o_done (mdone),
        .o_prod (prod)
    );

    p256dc_negate u_neg (
        .i_clk (i_clk),
        .i_en  (i_cmd.neg_en),
        .i_root(r_r),
        .o_neg (neg)
    );

    always_comb begin
        xin    = {i_req.x_w3, i_req.x_w2, i_req.x_w1, i_req.x_w0};
        pfx_ok = (i_req.prefix == p256dc_pkg::PREFIX_EVEN) ||
                 (i_req.prefix == p256dc_pkg::PREFIX_ODD);
        s1     = {1'b0, r_acc} + {1'b0, r_t};
        s1r    = (s1 >= {1'b0, p256dc_pkg::MOD_P}) ?
                 s1[255:0] - p256dc_pkg::MOD_P : s1[255:0];
        s2     = {1'b0, s1r} + {1'b0, p256dc_pkg::CURVE_B};
        s2r    = (s2 >= {1'b0, p256dc_pkg::MOD_P}) ?
                 s2[255:0] - p256dc_pkg::MOD_P : s2[255:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pfx_ok <= 1'b0;
        end else if (i_cmd.load) begin
            r_pfx_ok <= pfx_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= (xin >= p256dc_pkg::MOD_P) ? xin - p256dc_pkg::MOD_P : xin;
            r_want <= i_req.prefix[0];
        end
        if (i_cmd.alpha_fin) r_alpha <= s2r;
        if (i_cmd.r_init)    r_r     <= 256'd1;
        if (mdone) begin
            unique case (i_cmd.dst)
                p256dc_pkg::DST_ACC:   r_acc   <= prod;
                p256dc_pkg::DST_T:     r_t     <= prod;
                p256dc_pkg::DST_R:     r_r     <= prod;
                p256dc_pkg::DST_CHK:   r_chk   <= prod;
                p256dc_pkg::DST_ALPHA: r_alpha <= prod;
                default:               r_chk   <= prod;
            endcase
        end
        if (i_cmd.rsp_load) begin
            if (!r_pfx_ok) begin
                r_rsp <= '{status: p256dc_pkg::ST_BAD_PFX, default: '0};
            end else if (r_chk != r_alpha) begin
                r_rsp <= '{status: p256dc_pkg::ST_NO_ROOT, default: '0};
            end else if (r_r[0] == r_want) begin
                r_rsp <= '{p256dc_pkg::ST_OK, r_r[63:0], r_r[127:64],
                           r_r[191:128], r_r[255:192]};
            end else begin
                r_rsp <= '{p256dc_pkg::ST_OK, neg[63:0], neg[127:64],
                           neg[191:128], neg[255:192]};
            end
        end
    end

    assign o_sts.mul_done = mdone;
    assign o_sts.exp_bit  = p256dc_pkg::ROOT_EXP[i_bit_idx];
    assign o_pfx_ok       = r_pfx_ok;
    assign o_rsp          = r_rsp;

endmodule

### rtl/p256dc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// P-256 decompression controller
// Sequences the curve equation, the square-and-multiply root and the check.
// ----------------------------------------------------------------------------
module p256dc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_stall,
    input  p256dc_pkg::t_sts i_sts,
    input  logic             i_pfx_ok,
    output logic             o_stall,
    output logic             o_valid,
    output p256dc_pkg::t_cmd o_cmd,
    output logic [7:0]       o_bit_idx
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_CHKP  = 12'b000000000010,
        S_X2    = 12'b000000000100,
        S_X3    = 12'b000000001000,
        S_AX    = 12'b000000010000,
        S_ALPHA = 12'b000000100000,
        S_SQ    = 12'b000001000000,
        S_MUL   = 12'b000010000000,
        S_CHK   = 12'b000100000000,
        S_NEG   = 12'b001000000000,
        S_RSP   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_state     r_state, n_state;
    logic [7:0] r_idx, n_idx;
    logic       r_issued, n_issued;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_issued = r_issued;
        o_cmd    = '{op_a: p256dc_pkg::OP_X, op_b: p256dc_pkg::OP_X,
                     dst: p256dc_pkg::DST_ACC, default: '0};
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHKP;
                end
            end
            S_CHKP: begin
                n_issued = 1'b0;
                n_state  = i_pfx_ok ? S_X2 : S_RSP;
            end
            S_X2: begin
                o_cmd.dst = p256dc_pkg::DST_ACC;
                if (!r_issued) begin
                    o_cmd.mul_start = 1'b1;
                    n_issued = 1'b1;
                end else if (i_sts.mul_done) begin
                    n_issued = 1'b0;
                    n_state  = S_X3;
                end
            end
            S_X3: begin
                o_cmd.op_a = p256dc_pkg::OP_ACC;
                o_cmd.dst  = p256dc_pkg::DST_ACC;
                if (!r_issued) begin
                    o_cmd.mul_start = 1'b1;
                    n_issued = 1'b1;
                end else if (i_sts.mul_done) begin
                    n_issued = 1'b0;
                    n_state  = S_AX;
                end
            end
            S_AX: begin
                o_cmd.op_a = p256dc_pkg::OP_A;
                o_cmd.dst  = p256dc_pkg::DST_T;
                if (!r_issued) begin
                    o_cmd.mul_start = 1'b1;
                    n_issued = 1'b1;
                end else if (i_sts.mul_done) begin
                    n_issued = 1'b0;
                    n_state  = S_ALPHA;
                end
            end
            S_ALPHA: begin
                o_cmd.alpha_fin = 1'b1;
                o_cmd.r_init    = 1'b1;
                n_idx           = 8'd255;
                n_state         = S_SQ;
            end
            S_SQ: begin
                o_cmd.op_a = p256dc_pkg::OP_R;
                o_cmd.op_b = p256dc_pkg::OP_R;
                o_cmd.dst  = p256dc_pkg::DST_R;
                if (!r_issued) begin
                    o_cmd.mul_start = 1'b1;
                    n_issued = 1'b1;
                end else if (i_sts.mul_done) begin
                    n_issued = 1'b0;
                    if (i_sts.exp_bit) begin
                        n_state = S_MUL;
                    end else if (r_idx == 8'd0) begin
                        n_state = S_CHK;
                    end else begin
                        n_idx = r_idx - 8'd1;
                    end
                end
            end
            S_MUL: begin
                o_cmd.op_a = p256dc_pkg::OP_R;
                o_cmd.op_b = p256dc_pkg::OP_ALPHA;
                o_cmd.dst  = p256dc_pkg::DST_R;
                if (!r_issued) begin
                    o_cmd.mul_start = 1'b1;
                    n_issued = 1'b1;
                end else if (i_sts.mul_done) begin
                    n_issued = 1'b0;
                    if (r_idx == 8'd0) begin
                        n_state = S_CHK;
                    end else begin
                        n_idx   = r_idx - 8'd1;
                        n_state = S_SQ;
                    end
                end
            end
            S_CHK: begin
                o_cmd.op_a = p256dc_pkg::OP_R;
                o_cmd.op_b = p256dc_pkg::OP_R;
                o_cmd.dst  = p256dc_pkg::DST_CHK;
                if (!r_issued) begin
                    o_cmd.mul_start = 1'b1;
                    n_issued = 1'b1;
                end else if (i_sts.mul_done) begin
                    n_issued = 1'b0;
                    n_state  = S_NEG;
                end
            end
            S_NEG: begin
                o_cmd.op_a   = p256dc_pkg::OP_R;
                o_cmd.neg_en = 1'b1;
                n_state      = S_RSP;
            end
            S_RSP: begin
                o_cmd.rsp_load = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= 8'd0;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_issued <= n_issued;
        end
    end

    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = (r_state == S_OUT);
    assign o_bit_idx = r_idx;

endmodule

### rtl/p256dc_negate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// P-256 root negation
// Registers p - root for the opposite-parity answer.
// ----------------------------------------------------------------------------
module p256dc_negate (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [255:0] i_root,
    output logic [255:0] o_neg
);

    logic [255:0] r_neg;

    always_ff @(posedge i_clk) begin
        if (i_en) r_neg <= p256dc_pkg::MOD_P - i_root;
    end

    assign o_neg = r_neg;

endmodule

### rtl/p256_point_decompress_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// P-256 point decompression core
// Recovers y from a compressed key: prefix byte and 256-bit x.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel i_req_valid / o_req_stall / i_req carries prefix and x.
//   Response channel o_rsp_valid / i_rsp_stall / o_rsp carries status and y.
//   One request is in work at a time; o_req_stall is high from acceptance
//   until the response is taken.
//   A bad prefix skips the arithmetic: the controller goes from S_CHKP
//   through S_RSP to S_OUT, which raises o_rsp_valid. Otherwise three
//   products for alpha, square-and-multiply over 256 exponent bits and
//   one check product run on one bit-serial multiplier; the exponent
//   has 34 set bits, so 294 products a request.
//   The shared multiplier sets the time a request takes.
//   Reset clears the controller; any request in work is dropped.
//   While i_rsp_stall is high the response holds on o_rsp.
// ----------------------------------------------------------------------------
module p256_point_decompress_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    input  p256dc_pkg::t_req i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_stall,
    output p256dc_pkg::t_rsp o_rsp
);

    p256dc_pkg::t_cmd cmd;
    p256dc_pkg::t_sts sts;
    logic [7:0]       bit_idx;
    logic             pfx_ok;

    p256dc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_req_valid),
        .i_stall  (i_rsp_stall),
        .i_sts    (sts),
        .i_pfx_ok (pfx_ok),
        .o_stall  (o_req_stall),
        .o_valid  (o_rsp_valid),
        .o_cmd    (cmd),
        .o_bit_idx(bit_idx)
    );

    p256dc_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .i_bit_idx(bit_idx),
        .o_sts    (sts),
        .o_pfx_ok (pfx_ok),
        .o_rsp    (o_rsp)
    );

endmodule
